// File: rtl/core/tmp_pkg.sv
// tmp_pkg: shared types and constants of the trapezoidal motion profile block.
// Request and result structs, phase codes and register indexes.
// No dependencies.
`default_nettype none

package tmp_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIST_W        = 24;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned FRAC_W        = 17;
  localparam int unsigned FRAC_OUT_BITS = 16;
  localparam int unsigned PROD_W        = 2 * DIST_W;
  localparam int unsigned ROOT_W        = PROD_W / 2;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = DIST_W;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET = 24'd32768;
  localparam logic [FRAC_W-1:0]     FRAC_ONE  = 17'h10000;
  localparam logic [TIME_W-1:0]     TIME_MAX  = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_VELOCITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE      = 1'd1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [DIST_W-1:0] move_distance;
    logic [TIME_W-1:0] sample_time;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] position;
    logic [FRAC_W-1:0] fraction;
    logic [TIME_W-1:0] move_time;
    phase_t            phase;
    logic [DIST_W-1:0] peak_velocity;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/trapezoid_motion_profile.sv
// Trapezoidal velocity profile: plans a move from distance and configured
// velocity and acceleration, and samples it at the requested time.
//
// Requests (req) carry move_distance and sample_time; a request is taken on a
// rising edge with req_valid high and req_stall low. Results (res) leave on
// res_valid and are taken when res_stall is low. One result per request, in
// order. Write registers via wr_en / wr_index / wr_data only while no
// request is in flight; the block does not enforce it. Zero is used as one.
//
// Throughput is one request per cycle while req_stall is low. The square root
// takes 24 stages, the time dividers 24 + FRAC_BITS stages and the fraction
// divider 17. Reset clears all valid bits and loads both registers with 0.5
// (Q8.16). When the receiver stalls, the result is held and a one-entry skid
// catches the next one; req_stall then rises and the whole pipeline holds
// until the skid drains. req_stall comes straight from a register.
`default_nettype none

module trapezoid_motion_profile #(
  parameter int unsigned FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  tmp_pkg::req_t                  req,
  output logic                           res_valid,
  input  logic                           res_stall,
  output tmp_pkg::res_t                  res,
  input  logic                           wr_en,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tmp_pkg::CFG_DATA_W-1:0] wr_data
);

  import tmp_pkg::*;

  localparam int unsigned TW     = DIST_W + FRAC_BITS;
  localparam int unsigned TOT_W  = TW + 2;
  localparam int unsigned SW     = DIST_W + 2;
  localparam int unsigned MUL_W  = DIST_W + TIME_W;
  localparam int unsigned HALF_W = MUL_W / 2;
  localparam int unsigned PART_W = HALF_W + TIME_W;
  localparam int unsigned SQ_W   = MUL_W + TIME_W;
  localparam int unsigned SA_SH  = 2 * FRAC_BITS + 1;
  localparam int unsigned FDIV_W = DIST_W + FRAC_OUT_BITS;
  localparam int unsigned FDIV_Q = FRAC_OUT_BITS + 1;
  localparam int unsigned LAT    = 3 + ROOT_W + 1 + TW + 7 + FDIV_Q + 1;

  typedef struct packed {
    logic [DIST_W-1:0] d;
    logic [TIME_W-1:0] t;
    logic              is_tri;
  } cq_t;

  typedef struct packed {
    logic [DIST_W-1:0] d;
    logic [TIME_W-1:0] t;
    logic [DIST_W-1:0] vp;
    logic              is_tri;
  } cd_t;

  typedef struct packed {
    logic [DIST_W-1:0] s;
    phase_t            ph;
    logic [TIME_W-1:0] tot;
    logic [DIST_W-1:0] vp;
    logic              dz;
  } cf_t;

  // configuration
  logic [DIST_W-1:0] vel;
  logic [DIST_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vel <= CFG_RESET;
      acc <= CFG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_CRUISE_VELOCITY: vel <= (wr_data == '0) ? DIST_W'(1) : wr_data;
        REG_ACCEL_RATE:      acc <= (wr_data == '0) ? DIST_W'(1) : wr_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic           adv;
  logic           take;
  logic           skid_full;
  logic [LAT-1:0] vld;

  assign adv       = !skid_full;
  assign req_stall = skid_full;
  assign take      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], take};
    end
  end

  // stages 1 to 3: capture, products, shape test
  logic [DIST_W-1:0] d1, d2, d3;
  logic [TIME_W-1:0] t1, t2, t3;
  logic [PROD_W-1:0] ad2, vv2, ad3, vv3;
  logic              is_tri3;

  always_ff @(posedge clk) begin
    if (adv) begin
      d1      <= req.move_distance;
      t1      <= req.sample_time;
      d2      <= d1;
      t2      <= t1;
      ad2     <= PROD_W'(acc) * PROD_W'(d1);
      vv2     <= PROD_W'(vel) * PROD_W'(vel);
      d3      <= d2;
      t3      <= t2;
      ad3     <= ad2;
      vv3     <= vv2;
      is_tri3 <= (vv2 >= ad2);
    end
  end

  // square root of a*d, one root bit per stage
  logic [PROD_W-1:0] sq_x   [ROOT_W-1];
  logic [ROOT_W-1:0] sq_r   [ROOT_W];
  logic [ROOT_W+1:0] sq_rem [ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [PROD_W-1:0] x_in;
    logic [ROOT_W-1:0] r_in;
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W+3:0] rem2;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign x_in   = ad3;
      assign r_in   = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign x_in   = sq_x[k-1];
      assign r_in   = sq_r[k-1];
      assign rem_in = sq_rem[k-1];
    end

    assign rem2  = {rem_in, x_in[2*(ROOT_W-1-k) +: 2]};
    assign trial = {2'b00, r_in, 2'b01};
    assign diff  = rem2 - trial;
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k] <= {r_in[ROOT_W-2:0], ge};
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_x[k]   <= x_in;
          sq_rem[k] <= ge ? diff[ROOT_W+1:0] : rem2[ROOT_W+1:0];
        end
      end
    end
  end

  // trapezoid acceleration distance v*v / 2a, alongside the root
  logic [ROOT_W-1:0] da_q;

  tmp_divider #(
    .NUM_W(PROD_W),
    .DEN_W(DIST_W + 1),
    .QUO_W(ROOT_W)
  ) u_da_div (
    .clk (clk),
    .en  (adv),
    .num (vv3),
    .den ({acc, 1'b0}),
    .quo (da_q)
  );

  cq_t cq [ROOT_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      cq[0] <= '{d: d3, t: t3, is_tri: is_tri3};
      for (int i = 1; i < ROOT_W; i++) begin
        cq[i] <= cq[i-1];
      end
    end
  end

  // stage 4: peak velocity and divider operands
  logic [DIST_W-1:0] vp_sel;
  logic [DIST_W:0]   cruise_span;
  logic [TW-1:0]     num_ta4, num_tc4;
  logic [DIST_W-1:0] d4, vp4;
  logic [TIME_W-1:0] t4;
  logic              is_tri4;

  assign vp_sel      = cq[ROOT_W-1].is_tri ? sq_r[ROOT_W-1] : vel;
  assign cruise_span = (DIST_W+1)'(cq[ROOT_W-1].d) - {da_q, 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      num_ta4 <= {vp_sel, {FRAC_BITS{1'b0}}};
      num_tc4 <= {cruise_span[DIST_W-1:0], {FRAC_BITS{1'b0}}};
      d4      <= cq[ROOT_W-1].d;
      t4      <= cq[ROOT_W-1].t;
      vp4     <= vp_sel;
      is_tri4 <= cq[ROOT_W-1].is_tri;
    end
  end

  // ramp time and cruise time
  logic [TW-1:0] ta_q, tc_q;

  tmp_divider #(
    .NUM_W(TW),
    .DEN_W(DIST_W),
    .QUO_W(TW)
  ) u_ta_div (
    .clk (clk),
    .en  (adv),
    .num (num_ta4),
    .den (acc),
    .quo (ta_q)
  );

  tmp_divider #(
    .NUM_W(TW),
    .DEN_W(DIST_W),
    .QUO_W(TW)
  ) u_tc_div (
    .clk (clk),
    .en  (adv),
    .num (num_tc4),
    .den (vel),
    .quo (tc_q)
  );

  cd_t cd [TW];

  always_ff @(posedge clk) begin
    if (adv) begin
      cd[0] <= '{d: d4, t: t4, vp: vp4, is_tri: is_tri4};
      for (int i = 1; i < TW; i++) begin
        cd[i] <= cd[i-1];
      end
    end
  end

  // stage 5: totals
  logic [TW-1:0]     tc_sel;
  logic [TW-1:0]     ta5, tc5;
  logic [TOT_W-1:0]  tot5;
  logic [TW:0]       tatc5;
  logic [DIST_W-1:0] d5, vp5;
  logic [TIME_W-1:0] t5;

  assign tc_sel = cd[TW-1].is_tri ? '0 : tc_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      ta5   <= ta_q;
      tc5   <= tc_sel;
      tot5  <= TOT_W'({ta_q, 1'b0}) + TOT_W'(tc_sel);
      tatc5 <= (TW+1)'(ta_q) + (TW+1)'(tc_sel);
      d5    <= cd[TW-1].d;
      t5    <= cd[TW-1].t;
      vp5   <= cd[TW-1].vp;
    end
  end

  // stage 6: phase and multiplier operands
  logic [TOT_W-1:0]  t_ext;
  phase_t            ph_c;
  phase_t            ph6, ph7, ph8, ph9, ph10;
  logic [TIME_W-1:0] x16, u6, w6, tot6;
  logic [DIST_W-1:0] d6, vp6;

  assign t_ext = TOT_W'(t5);

  always_comb begin
    if (t5 == '0) begin
      ph_c = PH_IDLE;
    end else if (t_ext >= tot5) begin
      ph_c = PH_DONE;
    end else if (t_ext <= TOT_W'(ta5)) begin
      ph_c = PH_ACCEL;
    end else if (t_ext <= TOT_W'(tatc5)) begin
      ph_c = PH_CRUISE;
    end else begin
      ph_c = PH_DECEL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph6  <= ph_c;
      x16  <= (ph_c == PH_ACCEL) ? t5 : ta5[TIME_W-1:0];
      u6   <= t5 - tatc5[TIME_W-1:0];
      w6   <= (ph_c == PH_CRUISE) ? (t5 - ta5[TIME_W-1:0]) : tc5[TIME_W-1:0];
      tot6 <= (tot5 > TOT_W'(TIME_MAX)) ? TIME_MAX : tot5[TIME_W-1:0];
      d6   <= d5;
      vp6  <= vp5;
    end
  end

  // stage 7: first products
  logic [MUL_W-1:0]  p1_7, p2_7, m1_7, g7;
  logic [TIME_W-1:0] x17, u7, tot7, tot8, tot9, tot10;
  logic [DIST_W-1:0] d7, vp7, d8, vp8, d9, vp9, d10, vp10;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_7 <= MUL_W'(acc) * MUL_W'(x16);
      p2_7 <= MUL_W'(acc) * MUL_W'(u6);
      m1_7 <= MUL_W'(vp6) * MUL_W'(w6);
      g7   <= MUL_W'(vp6) * MUL_W'(u6);
      x17  <= x16;
      u7   <= u6;
      ph7  <= ph6;
      tot7 <= tot6;
      d7   <= d6;
      vp7  <= vp6;
    end
  end

  // stage 8: split squares into partial products
  logic [PART_W-1:0] pl1_8, ph1_8, pl2_8, ph2_8;
  logic [SW-1:0]     m1s8, g8;

  always_ff @(posedge clk) begin
    if (adv) begin
      pl1_8 <= PART_W'(p1_7[HALF_W-1:0]) * PART_W'(x17);
      ph1_8 <= PART_W'(p1_7[MUL_W-1:HALF_W]) * PART_W'(x17);
      pl2_8 <= PART_W'(p2_7[HALF_W-1:0]) * PART_W'(u7);
      ph2_8 <= PART_W'(p2_7[MUL_W-1:HALF_W]) * PART_W'(u7);
      m1s8  <= m1_7[FRAC_BITS +: SW];
      g8    <= g7[FRAC_BITS +: SW];
      ph8   <= ph7;
      tot8  <= tot7;
      d8    <= d7;
      vp8   <= vp7;
    end
  end

  // stage 9: combine partials, scale to distance
  logic [SQ_W-1:0] full1, full2;
  logic [SW-1:0]   sa1_9, sa2_9, m1s9, g9;

  assign full1 = SQ_W'(pl1_8) + {ph1_8, {HALF_W{1'b0}}};
  assign full2 = SQ_W'(pl2_8) + {ph2_8, {HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      sa1_9 <= full1[SA_SH +: SW];
      sa2_9 <= full2[SA_SH +: SW];
      m1s9  <= m1s8;
      g9    <= g8;
      ph9   <= ph8;
      tot9  <= tot8;
      d9    <= d8;
      vp9   <= vp8;
    end
  end

  // stage 10: cruise sum and net deceleration gain
  logic [SW:0]   base10;
  logic [SW-1:0] extra10, sa1_10;

  always_ff @(posedge clk) begin
    if (adv) begin
      base10  <= (SW+1)'(sa1_9) + (SW+1)'(m1s9);
      extra10 <= (g9 > sa2_9) ? (g9 - sa2_9) : '0;
      sa1_10  <= sa1_9;
      ph10    <= ph9;
      tot10   <= tot9;
      d10     <= d9;
      vp10    <= vp9;
    end
  end

  // stage 11: pick position and clamp to distance
  logic [SW+1:0]     s_raw;
  logic [DIST_W-1:0] s11, d11, vp11;
  phase_t            ph11;
  logic [TIME_W-1:0] tot11;
  logic              dz11;

  always_comb begin
    case (ph10)
      PH_IDLE:   s_raw = '0;
      PH_ACCEL:  s_raw = (SW+2)'(sa1_10);
      PH_CRUISE: s_raw = (SW+2)'(base10);
      PH_DECEL:  s_raw = (SW+2)'(base10) + (SW+2)'(extra10);
      PH_DONE:   s_raw = (SW+2)'(d10);
      default:   s_raw = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11   <= (s_raw > (SW+2)'(d10)) ? d10 : s_raw[DIST_W-1:0];
      d11   <= d10;
      dz11  <= (d10 == '0);
      ph11  <= ph10;
      tot11 <= tot10;
      vp11  <= vp10;
    end
  end

  // fraction s/d
  logic [FDIV_Q-1:0] frac_q;

  tmp_divider #(
    .NUM_W(FDIV_W),
    .DEN_W(DIST_W),
    .QUO_W(FDIV_Q)
  ) u_frac_div (
    .clk (clk),
    .en  (adv),
    .num ({s11, {FRAC_OUT_BITS{1'b0}}}),
    .den (d11),
    .quo (frac_q)
  );

  cf_t cf [FDIV_Q];

  always_ff @(posedge clk) begin
    if (adv) begin
      cf[0] <= '{s: s11, ph: ph11, tot: tot11, vp: vp11, dz: dz11};
      for (int i = 1; i < FDIV_Q; i++) begin
        cf[i] <= cf[i-1];
      end
    end
  end

  // final stage
  res_t fin;
  res_t skid;

  always_ff @(posedge clk) begin
    if (adv) begin
      fin.position      <= cf[FDIV_Q-1].s;
      fin.fraction      <= cf[FDIV_Q-1].dz ? '0 : FRAC_W'(frac_q);
      fin.move_time     <= cf[FDIV_Q-1].tot;
      fin.phase         <= cf[FDIV_Q-1].ph;
      fin.peak_velocity <= cf[FDIV_Q-1].vp;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!res_stall) begin
        skid_full <= 1'b0;
      end
    end else if (adv && vld[LAT-1]) begin
      res_valid <= 1'b1;
      if (res_valid && res_stall) begin
        skid_full <= 1'b1;
      end
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (!res_stall) begin
        res <= skid;
      end
    end else if (adv && vld[LAT-1]) begin
      if (res_valid && res_stall) begin
        skid <= fin;
      end else begin
        res <= fin;
      end
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> res_valid)
    else $error("skid holds a request while the output is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_full && !res_stall |=> !skid_full && res_valid)
    else $error("skid did not drain into the output");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    adv && vld[LAT-1] && res_valid && res_stall |=> skid_full)
    else $error("finished request dropped while output stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.phase == PH_IDLE |-> res.position == '0 && res.fraction == '0)
    else $error("non-zero position before move start");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.fraction <= FRAC_ONE)
    else $error("fraction above one");

endmodule

`default_nettype wire

// File: rtl/core/tmp_divider.sv
// tmp_divider: pipelined restoring divider, one quotient bit per stage.
// The upper dividend bits above the quotient width must be below the divisor.
// Depends on nothing; used by trapezoid_motion_profile.
`default_nettype none

module tmp_divider #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 24,
  parameter int unsigned QUO_W = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int unsigned HI_W = NUM_W - QUO_W;

  logic [DEN_W-1:0] rem_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [QUO_W-1:0] low_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      if (HI_W > 0) begin : g_hi
        assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
      end else begin : g_nohi
        assign rem_in = '0;
      end
      assign quo_in = '0;
      assign low_in = num[QUO_W-1:0];
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1-k]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[k] <= {quo_in[QUO_W-2:0], ge};
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          low_q[k] <= low_in;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

`default_nettype wire
